>>> src/eemp_pkg.sv
`default_nettype none
package eemp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_W      = 31;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned TOTAL_W    = 13;
    localparam int unsigned RUNE_W     = 21;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned LEN_W      = 3;
    localparam int unsigned PAYLOAD_W  = 156;
    localparam int unsigned TDATA_W    = 160;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd256;

    localparam logic [BYTE_W-1:0] CHAR_0       = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9       = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [NUM_W-1:0]  NUM_MAX  = 31'h7FFF_FFFF;
    localparam logic [RUNE_W-1:0] BAD_RUNE = 21'h00_FFFD;

    localparam logic [KIND_W-1:0] KIND_RUNE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NUM_SYNTAX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_NEWLINE = 2'd3;

    // Sequence length implied by a lead byte that is not plain ASCII.
    function automatic logic [LEN_W-1:0] need_of(input logic [BYTE_W-1:0] lead);
        logic [LEN_W-1:0] len;
        if (lead < 8'hE0) begin
            len = 3'd2;
        end else if (lead < 8'hF0) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Decodes a multi-byte sequence; malformed input gives the replacement rune.
    function automatic logic [RUNE_W-1:0] decode(
        input logic [BYTE_W-1:0] c0,
        input logic [BYTE_W-1:0] c1,
        input logic [BYTE_W-1:0] c2,
        input logic [BYTE_W-1:0] c3,
        input logic [LEN_W-1:0]  len
    );
        logic [10:0]       v2;
        logic [15:0]       v3;
        logic [RUNE_W-1:0] v4;
        logic [RUNE_W-1:0] r;
        v2 = {c0[4:0], c1[5:0]};
        v3 = {c0[3:0], c1[5:0], c2[5:0]};
        v4 = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
        if (len == 3'd2) begin
            if (!is_cont(c1) || c0 < 8'hC0 || v2 < 11'h080) begin
                r = BAD_RUNE;
            end else begin
                r = {10'd0, v2};
            end
        end else if (len == 3'd3) begin
            if (!is_cont(c1) || !is_cont(c2) || v3 < 16'h0800
                || (v3 >= 16'hD800 && v3 <= 16'hDFFF)) begin
                r = BAD_RUNE;
            end else begin
                r = {5'd0, v3};
            end
        end else begin
            if (!is_cont(c1) || !is_cont(c2) || !is_cont(c3) || c0 >= 8'hF8
                || v4 < 21'h01_0000 || v4 > 21'h10_FFFF) begin
                r = BAD_RUNE;
            end else begin
                r = v4;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/editor_event_message_parser.sv
`default_nettype none
// Event message parser.
// One byte enters per transfer on the input stream. A message is two tag
// bytes, four space-terminated decimal numbers (start, end, flag, rune count),
// that many UTF-8 runes and a newline. Each completed rune gives one output
// transfer of kind rune with its code point; the newline gives one of kind
// event with the header fields and the byte total; a bad number terminator,
// a rune count above the configured limit or a missing newline gives one of
// kind error, after which the parser expects a new first tag byte.
// The kind travels on tuser, all other fields on tdata.
// A byte is parsed in the cycle it is accepted and its result, if any, is
// registered and presented from the output register. One byte is accepted
// per cycle for as long as the output register is empty or being emptied.
// When the receiver stalls, the held result stays put and input is refused.
// The limit register resets to 256 and may be written while the block is idle.
// Reset clears the output register and returns the parser to the first tag.
module editor_event_message_parser (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [eemp_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: in_byte [7:0]
    input  wire logic [eemp_pkg::BYTE_W-1:0]        i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: status [1:0], rune_value [22:2], tag_first [30:23],
    // tag_second [38:31], start_pos [69:39], end_pos [100:70],
    // flag_value [131:101], rune_total [142:132], byte_total [155:143],
    // zeros [159:156]
    output logic [eemp_pkg::TDATA_W-1:0]            o_m_axis_tdata,
    // tuser: kind [1:0]
    output logic [eemp_pkg::KIND_W-1:0]             o_m_axis_tuser
);
    import eemp_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG1,
        PH_TAG2,
        PH_START,
        PH_END,
        PH_FLAG,
        PH_COUNT,
        PH_RUNES,
        PH_NEWLINE
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [COUNT_W-1:0]    r_limit;
    logic [BYTE_W-1:0]     r_tag_first, n_tag_first;
    logic [BYTE_W-1:0]     r_tag_second, n_tag_second;
    logic [NUM_W-1:0]      r_start, n_start;
    logic [NUM_W-1:0]      r_end, n_end;
    logic [NUM_W-1:0]      r_flag, n_flag;
    logic [NUM_W-1:0]      r_acc, n_acc;
    logic [COUNT_W-1:0]    r_remaining, n_remaining;
    logic [COUNT_W-1:0]    r_rune_total, n_rune_total;
    logic [TOTAL_W-1:0]    r_bytes_seen, n_bytes_seen;
    logic [BYTE_W-1:0]     r_pend0, r_pend1, r_pend2;
    logic [BYTE_W-1:0]     n_pend0, n_pend1, n_pend2;
    logic [LEN_W-1:0]      r_pend_count, n_pend_count;

    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_out_kind, n_out_kind;
    logic [PAYLOAD_W-1:0]  r_out_data, n_out_data;
    logic                  res_valid;

    logic                  accept;
    logic [BYTE_W-1:0]     in_byte;
    logic [NUM_W+3:0]      acc_x10;
    logic [NUM_W-1:0]      acc_sat;
    logic [LEN_W-1:0]      lead_len;
    logic                  rune_done;
    logic [RUNE_W-1:0]     rune_val;
    logic [LEN_W-1:0]      rune_len;
    logic                  err;
    logic [STATUS_W-1:0]   err_status;
    logic [COUNT_W-1:0]    remaining_dec;

    assign in_byte         = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Multiply by ten as two shifts, then add the digit, which is the low
    // nibble of an ASCII digit; anything past 31 bits saturates.
    assign acc_x10 = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                     + {{NUM_W{1'b0}}, in_byte[3:0]};
    assign acc_sat = (acc_x10[NUM_W+3:NUM_W] != 4'd0) ? NUM_MAX : acc_x10[NUM_W-1:0];

    assign lead_len      = need_of(r_pend0);
    assign remaining_dec = r_remaining - 11'd1;

    always_comb begin
        n_phase      = r_phase;
        n_tag_first  = r_tag_first;
        n_tag_second = r_tag_second;
        n_start      = r_start;
        n_end        = r_end;
        n_flag       = r_flag;
        n_acc        = r_acc;
        n_remaining  = r_remaining;
        n_rune_total = r_rune_total;
        n_bytes_seen = r_bytes_seen;
        n_pend0      = r_pend0;
        n_pend1      = r_pend1;
        n_pend2      = r_pend2;
        n_pend_count = r_pend_count;
        rune_done    = 1'b0;
        rune_val     = '0;
        rune_len     = 3'd1;
        err          = 1'b0;
        err_status   = ST_OK;
        res_valid    = 1'b0;
        n_out_kind   = KIND_RUNE;
        n_out_data   = '0;

        case (r_phase)
            PH_TAG1: begin
                n_tag_first = in_byte;
                n_phase     = PH_TAG2;
            end
            PH_TAG2: begin
                n_tag_second = in_byte;
                n_acc        = '0;
                n_phase      = PH_START;
            end
            PH_START, PH_END, PH_FLAG, PH_COUNT: begin
                if (in_byte inside {[CHAR_0:CHAR_9]}) begin
                    n_acc = acc_sat;
                end else if (in_byte != CHAR_SPACE) begin
                    err        = 1'b1;
                    err_status = ST_NUM_SYNTAX;
                end else if (r_phase == PH_COUNT) begin
                    if (r_acc > {{(NUM_W-COUNT_W){1'b0}}, r_limit}) begin
                        err        = 1'b1;
                        err_status = ST_TOO_LONG;
                    end else begin
                        n_rune_total = r_acc[COUNT_W-1:0];
                        n_remaining  = r_acc[COUNT_W-1:0];
                        n_bytes_seen = '0;
                        n_pend_count = '0;
                        n_phase = (r_acc[COUNT_W-1:0] != '0) ? PH_RUNES : PH_NEWLINE;
                    end
                end else begin
                    case (r_phase)
                        PH_START: n_start = r_acc;
                        PH_END:   n_end   = r_acc;
                        default:  n_flag  = r_acc;
                    endcase
                    n_acc   = '0;
                    n_phase = t_phase'(r_phase + 3'd1);
                end
            end
            PH_RUNES: begin
                if (r_pend_count == 3'd0) begin
                    if (in_byte < 8'h80) begin
                        rune_done = 1'b1;
                        rune_val  = {13'd0, in_byte};
                        rune_len  = 3'd1;
                    end else begin
                        n_pend0      = in_byte;
                        n_pend_count = 3'd1;
                    end
                end else if (r_pend_count + 3'd1 >= lead_len) begin
                    // The current byte completes the sequence as its last byte.
                    rune_done = 1'b1;
                    rune_len  = lead_len;
                    rune_val  = decode(r_pend0,
                                       (lead_len == 3'd2) ? in_byte : r_pend1,
                                       (lead_len == 3'd3) ? in_byte : r_pend2,
                                       in_byte, lead_len);
                end else begin
                    if (r_pend_count == 3'd1) begin
                        n_pend1 = in_byte;
                    end else begin
                        n_pend2 = in_byte;
                    end
                    n_pend_count = r_pend_count + 3'd1;
                end
            end
            PH_NEWLINE: begin
                if (in_byte != CHAR_NEWLINE) begin
                    err        = 1'b1;
                    err_status = ST_NO_NEWLINE;
                end else begin
                    res_valid  = 1'b1;
                    n_out_kind = KIND_EVENT;
                    n_out_data = {r_bytes_seen, r_rune_total, r_flag, r_end, r_start,
                                  r_tag_second, r_tag_first, {RUNE_W{1'b0}}, ST_OK};
                    n_phase    = PH_TAG1;
                end
            end
            default: begin
                n_phase = PH_TAG1;
            end
        endcase

        if (rune_done) begin
            res_valid    = 1'b1;
            n_out_kind   = KIND_RUNE;
            n_out_data   = {{(PAYLOAD_W-RUNE_W-STATUS_W){1'b0}}, rune_val, ST_OK};
            n_bytes_seen = r_bytes_seen + {{(TOTAL_W-LEN_W){1'b0}}, rune_len};
            n_pend_count = '0;
            n_remaining  = remaining_dec;
            if (remaining_dec == '0) begin
                n_phase = PH_NEWLINE;
            end
        end

        if (err) begin
            res_valid    = 1'b1;
            n_out_kind   = KIND_ERROR;
            n_out_data   = {{(PAYLOAD_W-STATUS_W){1'b0}}, err_status};
            n_phase      = PH_TAG1;
            n_pend_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG1;
            r_pend_count <= '0;
            r_limit      <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_pend_count <= n_pend_count;
                r_out_valid  <= res_valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; the parser writes each before it is read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag_first  <= n_tag_first;
            r_tag_second <= n_tag_second;
            r_start      <= n_start;
            r_end        <= n_end;
            r_flag       <= n_flag;
            r_acc        <= n_acc;
            r_remaining  <= n_remaining;
            r_rune_total <= n_rune_total;
            r_bytes_seen <= n_bytes_seen;
            r_pend0      <= n_pend0;
            r_pend1      <= n_pend1;
            r_pend2      <= n_pend2;
            if (res_valid) begin
                r_out_kind <= n_out_kind;
                r_out_data <= n_out_data;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {{(TDATA_W-PAYLOAD_W){1'b0}}, r_out_data};

endmodule
`default_nettype wire

>>> tb/sv/eemp_result_checker.sv
module eemp_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [eemp_pkg::COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [eemp_pkg::BYTE_W-1:0]   i_s_axis_tdata,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [eemp_pkg::TDATA_W-1:0]  i_m_axis_tdata,
    input  logic [eemp_pkg::KIND_W-1:0]   i_m_axis_tuser,
    output int                            o_awaited,
    output int                            o_failures
);
    import eemp_pkg::*;

    localparam int RUNE_LSB  = STATUS_W;
    localparam int TAG1_LSB  = RUNE_LSB + RUNE_W;
    localparam int TAG2_LSB  = TAG1_LSB + BYTE_W;
    localparam int START_LSB = TAG2_LSB + BYTE_W;
    localparam int END_LSB   = START_LSB + NUM_W;
    localparam int FLAG_LSB  = END_LSB + NUM_W;
    localparam int COUNT_LSB = FLAG_LSB + NUM_W;
    localparam int BYTES_LSB = COUNT_LSB + COUNT_W;

    typedef enum logic [2:0] {
        AWAIT_TAG1,
        AWAIT_TAG2,
        NUM_START,
        NUM_END,
        NUM_FLAG,
        NUM_COUNT,
        IN_RUNES,
        AWAIT_NEWLINE
    } parse_phase_e;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic [RUNE_W-1:0]   rune_value;
        logic [BYTE_W-1:0]   tag_first;
        logic [BYTE_W-1:0]   tag_second;
        logic [NUM_W-1:0]    start_pos;
        logic [NUM_W-1:0]    end_pos;
        logic [NUM_W-1:0]    flag_value;
        logic [COUNT_W-1:0]  rune_total;
        logic [TOTAL_W-1:0]  byte_total;
    } parse_result_t;

    parse_phase_e              phase;
    logic [COUNT_W-1:0]        count_limit;
    logic [BYTE_W-1:0]         tag_a;
    logic [BYTE_W-1:0]         tag_b;
    logic [NUM_W-1:0]          start_hold;
    logic [NUM_W-1:0]          end_hold;
    logic [NUM_W-1:0]          flag_hold;
    logic [NUM_W-1:0]          accum;
    logic [COUNT_W-1:0]        runes_left;
    logic [COUNT_W-1:0]        rune_count;
    logic [TOTAL_W-1:0]        rune_bytes;
    logic [3:0][BYTE_W-1:0]    seq_bytes;
    logic [2:0]                seq_len;
    parse_result_t             awaited_results[$];
    int                        fail_total = 0;

    function automatic logic [2:0] seq_length(input logic [BYTE_W-1:0] lead);
        if (lead >= 8'hF0) begin
            return 3'd4;
        end
        return (lead >= 8'hE0) ? 3'd3 : 3'd2;
    endfunction

    // Anything malformed collapses to the replacement character.
    function automatic logic [RUNE_W-1:0] code_point(input logic [3:0][BYTE_W-1:0] s,
                                                     input int n);
        logic [RUNE_W-1:0] v;
        bit                bad;
        bad = 1'b0;
        for (int i = 1; i < n; i++) begin
            if (s[i][7:6] != 2'b10) begin
                bad = 1'b1;
            end
        end
        case (n)
            2: begin
                v = {10'd0, s[0][4:0], s[1][5:0]};
                if (s[0] < 8'hC0 || v < 21'h80) begin
                    bad = 1'b1;
                end
            end
            3: begin
                v = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
                if (v < 21'h800 || (v >= 21'hD800 && v <= 21'hDFFF)) begin
                    bad = 1'b1;
                end
            end
            default: begin
                v = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
                if (s[0] >= 8'hF8 || v < 21'h1_0000 || v > 21'h10_FFFF) begin
                    bad = 1'b1;
                end
            end
        endcase
        return bad ? BAD_RUNE : v;
    endfunction

    task automatic raise_error(input logic [STATUS_W-1:0] code, output parse_result_t res);
        res = '0;
        res.kind = KIND_ERROR;
        res.status = code;
        phase = AWAIT_TAG1;
        seq_len = '0;
    endtask

    task automatic finish_rune(input logic [RUNE_W-1:0] value, input logic [2:0] nbytes,
                               output parse_result_t res);
        res = '0;
        res.kind = KIND_RUNE;
        res.status = ST_OK;
        res.rune_value = value;
        rune_bytes = rune_bytes + TOTAL_W'(nbytes);
        seq_len = '0;
        runes_left = runes_left - 1'b1;
        if (runes_left == '0) begin
            phase = AWAIT_NEWLINE;
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, output bit has_result,
                              output parse_result_t res);
        logic [63:0] wide;
        has_result = 1'b0;
        res = '0;
        case (phase)
            AWAIT_TAG1: begin
                tag_a = b;
                phase = AWAIT_TAG2;
            end
            AWAIT_TAG2: begin
                tag_b = b;
                accum = '0;
                phase = NUM_START;
            end
            NUM_START, NUM_END, NUM_FLAG, NUM_COUNT: begin
                if (b >= CHAR_0 && b <= CHAR_9) begin
                    wide = 64'(accum) * 64'd10 + 64'(b - CHAR_0);
                    accum = (wide > 64'(NUM_MAX)) ? NUM_MAX : wide[NUM_W-1:0];
                end else if (b != CHAR_SPACE) begin
                    raise_error(ST_NUM_SYNTAX, res);
                    has_result = 1'b1;
                end else begin
                    case (phase)
                        NUM_START: begin
                            start_hold = accum;
                            accum = '0;
                            phase = NUM_END;
                        end
                        NUM_END: begin
                            end_hold = accum;
                            accum = '0;
                            phase = NUM_FLAG;
                        end
                        NUM_FLAG: begin
                            flag_hold = accum;
                            accum = '0;
                            phase = NUM_COUNT;
                        end
                        default: begin
                            if (accum > count_limit) begin
                                raise_error(ST_TOO_LONG, res);
                                has_result = 1'b1;
                            end else begin
                                rune_count = accum[COUNT_W-1:0];
                                runes_left = accum[COUNT_W-1:0];
                                rune_bytes = '0;
                                seq_len = '0;
                                phase = (runes_left != '0) ? IN_RUNES : AWAIT_NEWLINE;
                            end
                        end
                    endcase
                end
            end
            IN_RUNES: begin
                if (seq_len == '0) begin
                    if (b < 8'h80) begin
                        finish_rune({13'd0, b}, 3'd1, res);
                        has_result = 1'b1;
                    end else begin
                        seq_bytes[0] = b;
                        seq_len = 3'd1;
                    end
                end else begin
                    seq_bytes[seq_len[1:0]] = b;
                    seq_len = seq_len + 3'd1;
                    if (seq_len == seq_length(seq_bytes[0])) begin
                        finish_rune(code_point(seq_bytes, seq_len), seq_len, res);
                        has_result = 1'b1;
                    end
                end
            end
            default: begin
                if (b != CHAR_NEWLINE) begin
                    raise_error(ST_NO_NEWLINE, res);
                end else begin
                    res.kind = KIND_EVENT;
                    res.status = ST_OK;
                    res.tag_first = tag_a;
                    res.tag_second = tag_b;
                    res.start_pos = start_hold;
                    res.end_pos = end_hold;
                    res.flag_value = flag_hold;
                    res.rune_total = rune_count;
                    res.byte_total = rune_bytes;
                    phase = AWAIT_TAG1;
                end
                has_result = 1'b1;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        parse_result_t due;
        bit            has_result;
        if (!i_rst_n) begin
            phase = AWAIT_TAG1;
            count_limit = LIMIT_RESET;
            tag_a = '0;
            tag_b = '0;
            start_hold = '0;
            end_hold = '0;
            flag_hold = '0;
            accum = '0;
            runes_left = '0;
            rune_count = '0;
            rune_bytes = '0;
            seq_len = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                count_limit = i_cfg_wr_data;
            end
            // The output transfer always belongs to an earlier byte, so it is
            // matched before this edge's input byte is parsed.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing awaited, kind %0d", i_m_axis_tuser);
                    fail_total++;
                end else begin
                    due = awaited_results.pop_front();
                    compare_field("kind", due.kind, i_m_axis_tuser);
                    compare_field("status", due.status, i_m_axis_tdata[STATUS_W-1:0]);
                    compare_field("rune_value", due.rune_value,
                                  i_m_axis_tdata[RUNE_LSB +: RUNE_W]);
                    compare_field("tag_first", due.tag_first,
                                  i_m_axis_tdata[TAG1_LSB +: BYTE_W]);
                    compare_field("tag_second", due.tag_second,
                                  i_m_axis_tdata[TAG2_LSB +: BYTE_W]);
                    compare_field("start_pos", due.start_pos,
                                  i_m_axis_tdata[START_LSB +: NUM_W]);
                    compare_field("end_pos", due.end_pos, i_m_axis_tdata[END_LSB +: NUM_W]);
                    compare_field("flag_value", due.flag_value,
                                  i_m_axis_tdata[FLAG_LSB +: NUM_W]);
                    compare_field("rune_total", due.rune_total,
                                  i_m_axis_tdata[COUNT_LSB +: COUNT_W]);
                    compare_field("byte_total", due.byte_total,
                                  i_m_axis_tdata[BYTES_LSB +: TOTAL_W]);
                    compare_field("tdata padding", '0,
                                  i_m_axis_tdata[TDATA_W-1:PAYLOAD_W]);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, has_result, due);
                if (has_result) begin
                    awaited_results.push_back(due);
                end
            end
        end
        o_awaited <= awaited_results.size();
        o_failures <= fail_total;
    end

endmodule

>>> tb/sv/tb_editor_event_message_parser.sv
module tb_editor_event_message_parser;
    import eemp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 300;
    localparam int HOLD_CYCLES = 150;

    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_OFF
    } idle_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    int                 awaited;
    int                 failures;

    idle_mode_e         idle_mode = IDLE_RX_HEAVY;
    logic               hold_toggle = 1'b0;
    logic               hold_seen = 1'b0;
    int                 hold_left = 0;
    int                 cycle_count = 0;
    logic [COUNT_W-1:0] active_limit = LIMIT_RESET;
    logic [BYTE_W-1:0]  msg_bytes[$];
    int                 phase_sent = 0;

    editor_event_message_parser u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    eemp_result_checker u_result_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_awaited       (awaited),
        .o_failures      (failures)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int idle_pct(input idle_mode_e mode, input bit sender);
        case (mode)
            IDLE_RX_HEAVY: return sender ? 11 : 71;
            IDLE_TX_HEAVY: return sender ? 71 : 11;
            default:       return 0;
        endcase
    endfunction

    // A toggle of hold_toggle starts a long stall on the result side.
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b0));
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct(idle_mode, 1'b1)) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        phase_sent++;
    endtask

    task automatic send_msg();
        foreach (msg_bytes[i]) begin
            send_byte(msg_bytes[i]);
        end
        msg_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        active_limit = value;
    endtask

    task automatic push_number(input logic [NUM_W-1:0] value, input bit lead_zero);
        string txt;
        txt = $sformatf("%0d", value);
        if (lead_zero) begin
            msg_bytes.push_back(CHAR_0);
        end
        for (int i = 0; i < txt.len(); i++) begin
            msg_bytes.push_back(txt[i]);
        end
        msg_bytes.push_back(CHAR_SPACE);
    endtask

    // Ten to fourteen random digits, which can run past the 31-bit ceiling.
    task automatic push_long_digits();
        repeat ($urandom_range(10, 14)) begin
            msg_bytes.push_back(CHAR_0 + 8'($urandom_range(9)));
        end
        msg_bytes.push_back(CHAR_SPACE);
    endtask

    task automatic push_header_number();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            push_number(NUM_W'($urandom_range(999)), 1'b0);
        end else if (r < 70) begin
            push_number(NUM_W'($urandom()), 1'b0);
        end else if (r < 82) begin
            push_long_digits();
        end else if (r < 90) begin
            msg_bytes.push_back(CHAR_SPACE);
        end else begin
            push_number(NUM_W'($urandom_range(99)), 1'b1);
        end
    endtask

    task automatic push_encoded(input logic [RUNE_W-1:0] cp, input int len);
        case (len)
            1: msg_bytes.push_back(cp[7:0]);
            2: begin
                msg_bytes.push_back({3'b110, cp[10:6]});
                msg_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                msg_bytes.push_back({4'b1110, cp[15:12]});
                msg_bytes.push_back({2'b10, cp[11:6]});
                msg_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                msg_bytes.push_back({5'b11110, cp[20:18]});
                msg_bytes.push_back({2'b10, cp[17:12]});
                msg_bytes.push_back({2'b10, cp[11:6]});
                msg_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic push_rune();
        int                r;
        int                len;
        int                tail;
        logic [BYTE_W-1:0] lead;
        r = $urandom_range(99);
        if (r < 35) begin
            push_encoded(RUNE_W'($urandom_range(127)), 1);
        end else if (r < 50) begin
            push_encoded(RUNE_W'($urandom_range(21'h80, 21'h7FF)), 2);
        end else if (r < 62) begin
            push_encoded(RUNE_W'($urandom_range(21'h800, 21'hFFFF)), 3);
        end else if (r < 72) begin
            push_encoded(RUNE_W'($urandom_range(21'h1_0000, 21'h10_FFFF)), 4);
        end else if (r < 82) begin
            // Overlong forms, surrogates and values beyond the Unicode range.
            len = $urandom_range(2, 4);
            if (len == 2) begin
                push_encoded(RUNE_W'($urandom_range(127)), 2);
            end else if (len == 3) begin
                push_encoded(RUNE_W'($urandom_range(1) ? $urandom_range(21'h7FF)
                                     : $urandom_range(21'hD800, 21'hDFFF)), 3);
            end else begin
                push_encoded(RUNE_W'($urandom_range(1) ? $urandom_range(21'hFFFF)
                                     : $urandom_range(21'h11_0000, 21'h1F_FFFF)), 4);
            end
        end else begin
            lead = BYTE_W'($urandom_range(128, 255));
            tail = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
            msg_bytes.push_back(lead);
            repeat (tail) begin
                msg_bytes.push_back($urandom_range(3) != 0 ? {2'b10, 6'($urandom())}
                                                           : 8'($urandom()));
            end
        end
    endtask

    task automatic build_message();
        int                r;
        int                n;
        int                lim;
        int                num_lo;
        int                num_hi;
        int                cut;
        logic [BYTE_W-1:0] junk;
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 5)) begin
                msg_bytes.push_back(8'($urandom()));
            end
            return;
        end
        msg_bytes.push_back(8'($urandom()));
        msg_bytes.push_back(8'($urandom()));
        num_lo = msg_bytes.size();
        repeat (3) push_header_number();
        lim = active_limit;
        r = $urandom_range(99);
        if (r < 65) begin
            n = $urandom_range(0, (lim < 6) ? lim : 6);
        end else if (r < 78) begin
            n = lim + 1;
        end else if (r < 90) begin
            n = (lim <= 24) ? lim : $urandom_range(7, 24);
        end else begin
            n = -1;
        end
        if (n < 0) begin
            push_long_digits();
        end else begin
            push_number(NUM_W'(n), $urandom_range(9) == 0);
        end
        num_hi = msg_bytes.size();
        if (n > 0 && n <= lim) begin
            repeat (n) push_rune();
        end
        msg_bytes.push_back(CHAR_NEWLINE);
        r = $urandom_range(99);
        if (r < 6) begin
            junk = BYTE_W'($urandom());
            msg_bytes.insert($urandom_range(num_lo, num_hi - 1), junk);
        end else if (r < 11) begin
            junk = BYTE_W'($urandom());
            msg_bytes[msg_bytes.size() - 1] = (junk == CHAR_NEWLINE) ? CHAR_SPACE : junk;
        end else if (r < 14) begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut) begin
                void'(msg_bytes.pop_back());
            end
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad number terminator straight after the tags.
        msg_bytes = '{8'h00, 8'hFF, 8'h78};
        send_msg();
        // Empty numbers and a zero rune count go straight to the newline.
        msg_bytes = '{8'h54, 8'h55, 8'h20, 8'h20, 8'h20, 8'h30, 8'h20, 8'h0A};
        send_msg();
        // A count of 257 is one above the limit after reset.
        msg_bytes = '{8'h45, 8'h52, 8'h31, 8'h20, 8'h32, 8'h20, 8'h33, 8'h20,
                      8'h32, 8'h35, 8'h37, 8'h20};
        send_msg();
        // A four-byte rune, a plain one and a surrogate, then no newline.
        msg_bytes = '{8'h4D, 8'h4E, 8'h20, 8'h20, 8'h20, 8'h33, 8'h20, 8'hF0,
                      8'h9F, 8'h98, 8'h80, 8'h41, 8'hED, 8'hA0, 8'h80, 8'h21};
        send_msg();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    write_limit(11'd1024);
                    hold_toggle <= ~hold_toggle;
                end
                2: begin
                    write_limit(11'd0);
                    idle_mode <= IDLE_TX_HEAVY;
                end
                3: write_limit(11'd3);
                4: begin
                    write_limit(COUNT_W'($urandom_range(1024)));
                    idle_mode <= IDLE_OFF;
                end
                5: write_limit(11'd20);
                default: ;
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                if (p == 3 && !paused && phase_sent > PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
                build_message();
                send_msg();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (10) @(posedge clk);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
